>>> rtl/glv_pkg.sv
// Shared types, constants and tables for the G-code line validator.
package glv_pkg;

    // Width of the count of missing fraction digits (covers up to six digits).
    localparam int PAD_W = 3;
    // Magnitude limit of a parsed value: 2^31.
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    // Quotient width of a 32-bit magnitude divided by 60.
    localparam int QUO_W = 27;
    // ceil(2^34 / 15): exact divide by 15 for inputs below 2^30.
    localparam logic [30:0] DIV15_MUL = 31'd1145324613;
    localparam int DIV15_SHIFT = 34;

    // Supported command codes.
    localparam logic [9:0] CODE_RAPID    = 10'd0;
    localparam logic [9:0] CODE_LINEAR   = 10'd1;
    localparam logic [9:0] CODE_METRIC   = 10'd21;
    localparam logic [9:0] CODE_HOME     = 10'd28;
    localparam logic [9:0] CODE_ABS      = 10'd90;
    localparam logic [9:0] CODE_REL      = 10'd91;
    localparam logic [9:0] CODE_EXT_TEMP = 10'd104;
    localparam logic [9:0] CODE_FAN_ON   = 10'd106;
    localparam logic [9:0] CODE_FAN_OFF  = 10'd107;
    localparam logic [9:0] CODE_EXT_WAIT = 10'd109;
    localparam logic [9:0] CODE_BED_TEMP = 10'd140;
    localparam logic [9:0] CODE_BED_WAIT = 10'd190;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_CODE   = 2'd1,
        PH_TOKENS = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        LTR_X    = 3'd0,
        LTR_Y    = 3'd1,
        LTR_Z    = 3'd2,
        LTR_E    = 3'd3,
        LTR_F    = 3'd4,
        LTR_S    = 3'd5,
        LTR_NONE = 3'd6
    } t_letter;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_LETTER  = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_BAD_PARAMS  = 2'd3
    } t_status;

    // Per-character line information moving down the pipe.
    typedef struct packed {
        logic       vld;
        logic       line_end;
        logic       letter_ok;
        logic       letter_is_m;
        logic [9:0] code;
    } t_line;

    // A finished token as seen by the scanner.
    typedef struct packed {
        logic             finish;
        logic             err;
        t_letter          letter;
        logic             neg;
        logic [PAD_W-1:0] pad;
        logic [31:0]      mag;
    } t_tok;

    // A finished token after scaling and the divide for F.
    typedef struct packed {
        logic             finish;
        logic             err;
        t_letter          letter;
        logic             neg;
        logic [31:0]      mag;
        logic [QUO_W-1:0] quo;
    } t_val;

    typedef struct packed {
        t_status          status;
        logic             is_m;
        logic [9:0]       code;
        logic [5:0][31:0] vals;
        logic [5:0]       mask;
        logic             abs_mode;
    } t_result;

    // 10^k for the missing fraction digits.
    function automatic logic [19:0] pow10(input logic [PAD_W-1:0] k);
        logic [19:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    // floor(2^31 / 10^k): above this the scaled value saturates.
    function automatic logic [31:0] sat_limit(input logic [PAD_W-1:0] k);
        logic [31:0] t;
        case (k)
            3'd0:    t = 32'd2147483648;
            3'd1:    t = 32'd214748364;
            3'd2:    t = 32'd21474836;
            3'd3:    t = 32'd2147483;
            3'd4:    t = 32'd214748;
            3'd5:    t = 32'd21474;
            3'd6:    t = 32'd2147;
            default: t = 32'd2147483648;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/glv_scan.sv
// Character scanner: code word, token state and number accumulation.
module glv_scan #(
    parameter int FRACTION_DIGITS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output glv_pkg::t_line o_line,
    output glv_pkg::t_tok  o_tok
);
    import glv_pkg::*;

    localparam int FW = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic logic [31:0] times_ten_sat(input logic [31:0] m, input logic [3:0] d);
        logic [35:0] t;
        t = {4'b0, m} * 36'd10 + {32'b0, d};
        return (t > {4'b0, MAG_CAP}) ? MAG_CAP : t[31:0];
    endfunction

    t_phase        r_phase, n_phase;
    logic          r_letter_ok, n_letter_ok;
    logic          r_letter_is_m, n_letter_is_m;
    logic [9:0]    r_code, n_code;
    logic          r_code_stop, n_code_stop;
    t_letter       r_tok_letter, n_tok_letter;
    logic [1:0]    r_tok_len, n_tok_len;
    logic [31:0]   r_num, n_num;
    logic [FW-1:0] r_frac, n_frac;
    logic          r_dot, n_dot;
    logic          r_neg, n_neg;
    logic          r_num_stop, n_num_stop;
    t_line         r_line, n_line;
    t_tok          r_tok, n_tok;

    logic          is_digit;
    logic          is_sep;
    logic [3:0]    digit;
    logic [13:0]   code_ext;
    t_letter       char_letter;

    assign digit    = i_char[3:0];
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_sep   = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign code_ext = {4'b0, r_code} * 14'd10 + {10'b0, digit};

    always_comb begin
        unique case (i_char)
            CH_X:    char_letter = LTR_X;
            CH_Y:    char_letter = LTR_Y;
            CH_Z:    char_letter = LTR_Z;
            CH_E:    char_letter = LTR_E;
            CH_F:    char_letter = LTR_F;
            CH_S:    char_letter = LTR_S;
            default: char_letter = LTR_NONE;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_letter_ok   = r_letter_ok;
        n_letter_is_m = r_letter_is_m;
        n_code        = r_code;
        n_code_stop   = r_code_stop;
        n_tok_letter  = r_tok_letter;
        n_tok_len     = r_tok_len;
        n_num         = r_num;
        n_frac        = r_frac;
        n_dot         = r_dot;
        n_neg         = r_neg;
        n_num_stop    = r_num_stop;
        n_tok         = '0;
        n_line        = '0;

        if (i_vld) begin
            unique case (r_phase)
                PH_START: begin
                    n_letter_ok   = (i_char == CH_G) || (i_char == CH_M);
                    n_letter_is_m = (i_char == CH_M);
                    n_code        = '0;
                    n_code_stop   = 1'b0;
                    n_phase       = PH_CODE;
                end
                PH_CODE: begin
                    if (i_char == CH_SPACE) begin
                        n_phase   = PH_TOKENS;
                        n_tok_len = 2'd0;
                    end else if (!r_code_stop && is_digit) begin
                        n_code = (code_ext > 14'd1023) ? 10'd1023 : code_ext[9:0];
                    end else begin
                        n_code_stop = 1'b1;
                    end
                end
                PH_TOKENS: begin
                    if (is_sep) begin
                        // separator closes the open token
                        if (r_tok_len != 2'd0) begin
                            n_tok.finish = 1'b1;
                            n_tok.err    = (r_tok_len == 2'd1) || (r_tok_letter == LTR_NONE);
                            n_tok.letter = r_tok_letter;
                            n_tok.neg    = r_neg;
                            n_tok.pad    = PAD_W'(FRACTION_DIGITS) - PAD_W'(r_frac);
                            n_tok.mag    = r_num;
                        end
                        n_tok_len = 2'd0;
                    end else if (r_tok_len == 2'd0) begin
                        n_tok_letter = char_letter;
                        n_tok_len    = 2'd1;
                        n_num        = '0;
                        n_frac       = '0;
                        n_dot        = 1'b0;
                        n_neg        = 1'b0;
                        n_num_stop   = 1'b0;
                    end else begin
                        if (!r_num_stop) begin
                            if ((r_tok_len == 2'd1) &&
                                ((i_char == CH_PLUS) || (i_char == CH_MINUS))) begin
                                n_neg = (i_char == CH_MINUS);
                            end else if (is_digit) begin
                                if (!r_dot) begin
                                    n_num = times_ten_sat(r_num, digit);
                                end else if (r_frac < FW'(FRACTION_DIGITS)) begin
                                    n_num  = times_ten_sat(r_num, digit);
                                    n_frac = r_frac + 1'b1;
                                end
                            end else if ((i_char == CH_DOT) && !r_dot) begin
                                n_dot = 1'b1;
                            end else begin
                                n_num_stop = 1'b1;
                            end
                        end
                        n_tok_len = 2'd2;
                    end
                end
                default: n_phase = PH_START;
            endcase

            // last character closes a token still open after this update
            if (i_last && (n_phase == PH_TOKENS) && (n_tok_len != 2'd0)) begin
                n_tok.finish = 1'b1;
                n_tok.err    = (n_tok_len == 2'd1) || (n_tok_letter == LTR_NONE);
                n_tok.letter = n_tok_letter;
                n_tok.neg    = n_neg;
                n_tok.pad    = PAD_W'(FRACTION_DIGITS) - PAD_W'(n_frac);
                n_tok.mag    = n_num;
            end

            n_line.vld         = 1'b1;
            n_line.line_end    = i_last;
            n_line.letter_ok   = n_letter_ok;
            n_line.letter_is_m = n_letter_is_m;
            n_line.code        = n_code;

            if (i_last) begin
                n_phase       = PH_START;
                n_letter_ok   = 1'b0;
                n_letter_is_m = 1'b0;
                n_code        = '0;
                n_code_stop   = 1'b0;
                n_tok_letter  = LTR_X;
                n_tok_len     = 2'd0;
                n_num         = '0;
                n_frac        = '0;
                n_dot         = 1'b0;
                n_neg         = 1'b0;
                n_num_stop    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_letter_ok   <= 1'b0;
            r_letter_is_m <= 1'b0;
            r_code        <= '0;
            r_code_stop   <= 1'b0;
            r_tok_letter  <= LTR_X;
            r_tok_len     <= 2'd0;
            r_num         <= '0;
            r_frac        <= '0;
            r_dot         <= 1'b0;
            r_neg         <= 1'b0;
            r_num_stop    <= 1'b0;
            r_line        <= '0;
            r_tok         <= '0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_letter_ok   <= n_letter_ok;
            r_letter_is_m <= n_letter_is_m;
            r_code        <= n_code;
            r_code_stop   <= n_code_stop;
            r_tok_letter  <= n_tok_letter;
            r_tok_len     <= n_tok_len;
            r_num         <= n_num;
            r_frac        <= n_frac;
            r_dot         <= n_dot;
            r_neg         <= n_neg;
            r_num_stop    <= n_num_stop;
            r_line        <= n_line;
            r_tok         <= n_tok;
        end
    end

    assign o_line = r_line;
    assign o_tok  = r_tok;

endmodule

>>> rtl/glv_scale.sv
// Value path: fraction scaling with saturation, then the divide by 60 for F.
module glv_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  glv_pkg::t_line i_line,
    input  glv_pkg::t_tok  i_tok,
    output glv_pkg::t_line o_line,
    output glv_pkg::t_val  o_val
);
    import glv_pkg::*;

    // stage 2: scale by 10^pad, saturate
    logic [19:0] pw;
    logic [31:0] lim;
    logic [51:0] prod_s;
    logic [31:0] n_mag;
    t_line       r_line2;
    t_val        r_val2;

    assign pw     = pow10(i_tok.pad);
    assign lim    = sat_limit(i_tok.pad);
    assign prod_s = {20'b0, i_tok.mag} * {32'b0, pw};

    always_comb begin
        n_mag = (i_tok.mag > lim) ? MAG_CAP : prod_s[31:0];
        if (!i_tok.neg && (n_mag > (MAG_CAP - 32'd1)))
            n_mag = MAG_CAP - 32'd1;
    end

    // stage 3: n / 60 = (n >> 2) / 15 by reciprocal multiply
    logic [60:0] prod_q;
    t_line       r_line3;
    t_val        r_val3;
    t_val        n_val3;

    assign prod_q = {31'b0, r_val2.mag[31:2]} * {30'b0, DIV15_MUL};

    always_comb begin
        n_val3     = r_val2;
        n_val3.quo = prod_q[DIV15_SHIFT +: QUO_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line2 <= '0;
            r_val2  <= '0;
            r_line3 <= '0;
            r_val3  <= '0;
        end else if (i_en) begin
            r_line2        <= i_line;
            r_val2.finish  <= i_tok.finish;
            r_val2.err     <= i_tok.err;
            r_val2.letter  <= i_tok.letter;
            r_val2.neg     <= i_tok.neg;
            r_val2.mag     <= n_mag;
            r_val2.quo     <= '0;
            r_line3        <= r_line2;
            r_val3         <= n_val3;
        end
    end

    assign o_line = r_line3;
    assign o_val  = r_val3;

endmodule

>>> rtl/glv_verdict.sv
// Parameter store, command rules and the result register.
module glv_verdict (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  glv_pkg::t_line   i_line,
    input  glv_pkg::t_val    i_val,
    input  logic             i_ready,
    output logic             o_vld,
    output glv_pkg::t_result o_res
);
    import glv_pkg::*;

    logic [5:0][31:0] r_params, n_params;
    logic [5:0]       r_seen, n_seen;
    logic             r_err, n_err;
    logic             r_abs, n_abs;
    logic             r_vld;
    t_result          r_res, n_res;

    logic [31:0] val;
    logic        any_tok;
    logic        ok;
    logic        known;
    logic        m_cls;

    always_comb begin
        val = (i_val.letter == LTR_F) ? {{(32-QUO_W){1'b0}}, i_val.quo} : i_val.mag;
        if (i_val.neg)
            val = 32'd0 - val;
    end

    // merge the incoming token into the store
    always_comb begin
        n_params = r_params;
        n_seen   = r_seen;
        n_err    = r_err;
        if (i_line.vld && i_val.finish) begin
            if (i_val.err) begin
                n_err = 1'b1;
            end else begin
                n_params[i_val.letter] = val;
                n_seen[i_val.letter]   = 1'b1;
            end
        end
    end

    always_comb begin
        any_tok = n_err || (n_seen != 6'd0);
        ok      = 1'b0;
        known   = 1'b1;
        m_cls   = 1'b0;
        unique case (i_line.code) inside
            CODE_RAPID, CODE_LINEAR:
                ok = !n_err && (n_seen[3:0] != 4'd0);
            CODE_HOME:
                ok = !any_tok || (!n_err && (n_seen[2:0] != 3'd0));
            CODE_METRIC, CODE_ABS, CODE_REL:
                ok = !any_tok;
            CODE_EXT_TEMP, CODE_EXT_WAIT, CODE_BED_TEMP, CODE_BED_WAIT, CODE_FAN_ON: begin
                m_cls = 1'b1;
                ok    = !n_err && n_seen[LTR_S] && (n_seen[4:0] == 5'd0);
            end
            CODE_FAN_OFF: begin
                m_cls = 1'b1;
                ok    = !any_tok;
            end
            default:
                known = 1'b0;
        endcase

        n_res      = '0;
        n_res.code = i_line.code;
        n_res.is_m = m_cls;
        n_abs      = r_abs;
        if (!i_line.letter_ok) begin
            n_res.status = ST_BAD_LETTER;
            n_res.is_m   = 1'b0;
            n_res.code   = '0;
        end else if (!known) begin
            n_res.status = ST_UNSUPPORTED;
            n_res.is_m   = i_line.letter_is_m;
        end else if (!ok) begin
            n_res.status = ST_BAD_PARAMS;
        end else begin
            n_res.status = ST_OK;
            n_res.vals   = n_params;
            n_res.mask   = n_seen;
            if (i_line.code == CODE_ABS)
                n_abs = 1'b1;
            if (i_line.code == CODE_REL)
                n_abs = 1'b0;
        end
        n_res.abs_mode = n_abs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_params <= '0;
            r_seen   <= '0;
            r_err    <= 1'b0;
            r_abs    <= 1'b1;
            r_vld    <= 1'b0;
            r_res    <= '0;
        end else begin
            // a new verdict wins over the handshake of the old one
            if (i_en && i_line.vld && i_line.line_end)
                r_vld <= 1'b1;
            else if (i_ready)
                r_vld <= 1'b0;
            if (i_en && i_line.vld) begin
                if (i_line.line_end) begin
                    r_params <= '0;
                    r_seen   <= '0;
                    r_err    <= 1'b0;
                    r_abs    <= n_abs;
                    r_res    <= n_res;
                end else begin
                    r_params <= n_params;
                    r_seen   <= n_seen;
                    r_err    <= n_err;
                end
            end
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

>>> rtl/gcode_line_validator_core.sv
// Top level of the G-code line validator: stream ports and pipeline control.
//
// Use: feed one command line on the slave stream, one ASCII character per item,
// with s_axis_tlast on the final character. For every line one verdict item
// leaves on the master stream: status, code number, the six parameter values
// (thousandths by default, F divided by 60), the mask of parameters seen and
// the positioning mode after the line. is_m_class travels on m_axis_tuser.
//
// Throughput: one character per clock while s_axis_tready is high. The design
// is a four-register pipe: scanner, fraction scaling, reciprocal multiply for
// the F divide, and the verdict/result register. A line's verdict shows on
// m_axis_tvalid once its last character has passed the first three registers.
//
// Reset (i_rst_n low, synchronous) empties the pipe, clears all line state
// and sets absolute positioning.
//
// Stall: characters keep flowing while a verdict waits in the result
// register; s_axis_tready drops only when a line end reaches the last stage
// and the waiting verdict has not been taken.
module gcode_line_validator_core #(
    parameter int FRACTION_DIGITS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] char_code
    input  logic          s_axis_tlast,   // last_char
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [1:0] status, [11:2] code_number, [43:12] x_value, [75:44] y_value,
    // [107:76] z_value, [139:108] e_value, [171:140] feed_value,
    // [203:172] s_value, [209:204] present_mask, [210] absolute_mode, [215:211] zero
    output logic [215:0]  m_axis_tdata,
    output logic          m_axis_tuser    // [0] is_m_class
);
    import glv_pkg::*;

    logic    en;
    t_line   scan_line;
    t_tok    scan_tok;
    t_line   val_line;
    t_val    val_tok;
    logic    res_vld;
    t_result res;

    // Hold the whole pipe only when a verdict would overwrite an untaken one.
    assign en = !(res_vld && !m_axis_tready && val_line.vld && val_line.line_end);
    assign s_axis_tready = en;

    glv_scan #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_line  (scan_line),
        .o_tok   (scan_tok)
    );

    glv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_line  (scan_line),
        .i_tok   (scan_tok),
        .o_line  (val_line),
        .o_val   (val_tok)
    );

    glv_verdict u_verdict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_line  (val_line),
        .i_val   (val_tok),
        .i_ready (m_axis_tready),
        .o_vld   (res_vld),
        .o_res   (res)
    );

    assign m_axis_tvalid = res_vld;
    assign m_axis_tuser  = res.is_m;
    assign m_axis_tdata  = {5'b0, res.abs_mode, res.mask, res.vals, res.code,
                            2'(res.status)};

endmodule
